@@ rtl/cswb_pkg.sv @@
package cswb_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int KEY_W   = 32;
   localparam int SLOT_W  = 6;
   localparam int USAGE_W = 4;
   localparam int PIN_W   = 8;
   localparam int CNT_W   = 7;

   localparam logic [2:0] CMD_ACCESS   = 3'd0;
   localparam logic [2:0] CMD_FINISH   = 3'd1;
   localparam logic [2:0] CMD_ALLOCATE = 3'd2;
   localparam logic [2:0] CMD_LOAD     = 3'd3;
   localparam logic [2:0] CMD_EVICT    = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_KEY_MISS   = 3'd1;
   localparam logic [2:0] ST_PIN_OVF    = 3'd2;
   localparam logic [2:0] ST_ALL_PINNED = 3'd3;
   localparam logic [2:0] ST_BAD_SLOT   = 3'd4;

   localparam logic [1:0] REG_MAX_USAGE = 2'd0;
   localparam logic [1:0] REG_CAPACITY  = 2'd1;
   localparam logic [1:0] REG_PIN_LIMIT = 2'd2;

   localparam logic [USAGE_W-1:0] MAX_USAGE_RST = 4'd5;
   localparam logic [CNT_W-1:0]   CAPACITY_RST  = 7'd64;
   localparam logic [PIN_W-1:0]   PIN_LIMIT_RST = 8'd80;

   localparam logic [USAGE_W-1:0] LOAD_USAGE = 4'd2;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [PIN_W-1:0]   pins;
      logic [USAGE_W-1:0] usage;
      logic               dirty;
   } entry_type;

endpackage

@@ rtl/clock_sweep_buffer_replacer.sv @@
// Clock-sweep buffer replacer. Slot entries (key, pin count, usage, dirty) live in one
// synchronous RAM; valid bits are flops. Access and finish read the entry, then modify
// and write it back. Allocate and load, while occupancy is below capacity, scan from slot
// 0 for the lowest free slot, one valid bit per cycle. Any sweep gives each slot the hand
// visits a RAM read, then an examine and write back; a victim usually comes within a few
// rounds, and all-pinned is reported after max_usage full rounds (one if max_usage is 0).
// Batch evict gives one result per victim as found. Results appear as a one-cycle
// rsp_valid strobe and cannot be held off; busy stays high until the final result
// (rsp_last) is shown. Unknown command codes are dropped with no result.
module clock_sweep_buffer_replacer
   import cswb_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [KEY_W-1:0]   req_key,
   input  logic               req_dirty,
   input  logic [CNT_W-1:0]   req_evict_count,
   output logic               rsp_valid,
   output logic [SLOT_W-1:0]  rsp_slot_out,
   output logic               rsp_victim_valid,
   output logic [KEY_W-1:0]   rsp_victim_key,
   output logic               rsp_victim_dirty,
   output logic [2:0]         rsp_status,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [PIN_W-1:0]   csr_wdata
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ACC_RD = 3'd1;
   localparam logic [2:0] S_ACC_EX = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_SW_RD  = 3'd4;
   localparam logic [2:0] S_SW_EX  = 3'd5;

   entry_type mem [SLOTS];
   entry_type rd_ff;
   logic      we;
   logic [IW-1:0] wa, ra;
   entry_type wd;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [IW-1:0]      slot_ff, slot_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               dirty_ff, dirty_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      found_ff, found_in;
   logic [IW-1:0]      start_ff, start_in;
   logic [USAGE_W-1:0] rounds_ff, rounds_in;
   logic [IW-1:0]      hand_ff, hand_in;
   logic [CW-1:0]      occ_ff, occ_in;
   logic [IW-1:0]      scan_ff, scan_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [USAGE_W-1:0] max_usage_ff, max_usage_in;
   logic [CNT_W-1:0]   capacity_ff, capacity_in;
   logic [PIN_W-1:0]   pin_limit_ff, pin_limit_in;

   logic               rv_ff, rv_in;
   logic [SLOT_W-1:0]  rslot_ff, rslot_in;
   logic               rvv_ff, rvv_in;
   logic [KEY_W-1:0]   rvk_ff, rvk_in;
   logic               rvd_ff, rvd_in;
   logic [2:0]         rst_ff, rst_in;
   logic               rlast_ff, rlast_in;

   logic [USAGE_W-1:0] lim;
   logic [IW-1:0]      idx, hand_nx;
   logic [IW:0]        hand_inc;
   logic               slot_bad;
   logic [PIN_W-1:0]   pins_new;
   logic [USAGE_W-1:0] use_new;

   function automatic logic [USAGE_W-1:0] sat_add(input logic [USAGE_W-1:0] u,
                                                   input logic [USAGE_W-1:0] n,
                                                   input logic [USAGE_W-1:0] m);
      logic [USAGE_W:0] s;
      s = {1'b0, u} + {1'b0, n};
      return (s > {1'b0, m}) ? m : s[USAGE_W-1:0];
   endfunction

   assign lim       = (max_usage_ff == '0) ? USAGE_W'(1) : max_usage_ff;
   assign idx       = IW'(req_slot);
   assign slot_bad  = (32'(req_slot) >= SLOTS) || !valid_ff[idx];
   assign hand_inc  = {1'b0, hand_ff} + 1'b1;
   assign hand_nx   = (hand_ff == LAST_IDX) ? '0 : hand_inc[IW-1:0];
   assign ra        = (state_ff == S_ACC_RD) ? slot_ff : hand_ff;
   assign pins_new  = (cmd_ff == CMD_ALLOCATE) ? PIN_W'(1) : '0;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   always_comb begin
      state_in = state_ff;   cmd_in = cmd_ff;       slot_in = slot_ff;
      key_in = key_ff;       dirty_in = dirty_ff;   cnt_in = cnt_ff;
      found_in = found_ff;   start_in = start_ff;   rounds_in = rounds_ff;
      hand_in = hand_ff;     occ_in = occ_ff;       scan_in = scan_ff;
      valid_in = valid_ff;
      max_usage_in = max_usage_ff; capacity_in = capacity_ff; pin_limit_in = pin_limit_ff;
      rv_in = 1'b0;  rslot_in = rslot_ff; rvv_in = 1'b0; rvk_in = '0; rvd_in = 1'b0;
      rst_in = ST_OK; rlast_in = 1'b1;
      we = 1'b0; wa = hand_ff; wd = rd_ff; use_new = '0;

      if (csr_valid) begin
         case (csr_index)
            REG_MAX_USAGE: max_usage_in = csr_wdata[USAGE_W-1:0];
            REG_CAPACITY:  capacity_in  = csr_wdata[CNT_W-1:0];
            REG_PIN_LIMIT: pin_limit_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_cmd; slot_in = idx; key_in = req_key; dirty_in = req_dirty;
               cnt_in = (32'(req_evict_count) > SLOTS) ? CW'(SLOTS) : CW'(req_evict_count);
               found_in = '0; rounds_in = '0; start_in = hand_ff; scan_in = '0;
               case (req_cmd)
                  CMD_ACCESS, CMD_FINISH: begin
                     if (slot_bad) begin
                        rv_in = 1'b1; rslot_in = req_slot; rst_in = ST_BAD_SLOT;
                     end else begin
                        state_in = S_ACC_RD;
                     end
                  end
                  CMD_ALLOCATE, CMD_LOAD: begin
                     if (occ_ff < capacity_ff && 32'(occ_ff) < SLOTS) state_in = S_SCAN;
                     else state_in = S_SW_RD;
                  end
                  CMD_EVICT: begin
                     if (req_evict_count == '0) begin
                        rv_in = 1'b1; rslot_in = '0;
                     end else begin
                        state_in = S_SW_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ACC_RD: state_in = S_ACC_EX;
         S_ACC_EX: begin
            state_in = S_IDLE;
            rv_in = 1'b1; rslot_in = SLOT_W'(slot_ff);
            wa = slot_ff; wd = rd_ff;
            if (cmd_ff == CMD_ACCESS) begin
               if (rd_ff.key != key_ff) rst_in = ST_KEY_MISS;
               else if (rd_ff.pins >= pin_limit_ff) rst_in = ST_PIN_OVF;
               else begin
                  we = 1'b1;
                  wd.pins  = rd_ff.pins + 1'b1;
                  wd.usage = sat_add(rd_ff.usage, USAGE_W'(1), lim);
               end
            end else begin
               we = 1'b1;
               if (rd_ff.pins != '0) wd.pins = rd_ff.pins - 1'b1;
               if (dirty_ff) begin
                  wd.dirty = 1'b1;
                  wd.usage = sat_add(rd_ff.usage, USAGE_W'(1), lim);
               end
            end
         end
         S_SCAN: begin
            if (!valid_ff[scan_ff]) begin
               use_new = sat_add('0, (cmd_ff == CMD_ALLOCATE) ? USAGE_W'(1) : LOAD_USAGE,
                                 lim);
               we = 1'b1; wa = scan_ff;
               wd.key = key_ff; wd.pins = pins_new; wd.usage = use_new; wd.dirty = 1'b0;
               valid_in[scan_ff] = 1'b1;
               occ_in = occ_ff + 1'b1;
               rv_in = 1'b1; rslot_in = SLOT_W'(scan_ff);
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_SW_RD: state_in = S_SW_EX;
         S_SW_EX: begin
            hand_in = hand_nx;
            state_in = S_SW_RD;
            if (valid_ff[hand_ff] && rd_ff.pins == '0) begin
               if (rd_ff.usage != '0) begin
                  we = 1'b1; wd = rd_ff; wd.usage = rd_ff.usage - 1'b1;
               end else begin
                  // victim found
                  rv_in = 1'b1; rslot_in = SLOT_W'(hand_ff); rvv_in = 1'b1;
                  rvk_in = rd_ff.key; rvd_in = rd_ff.dirty;
                  if (cmd_ff == CMD_EVICT) begin
                     valid_in[hand_ff] = 1'b0;
                     occ_in = occ_ff - 1'b1;
                     found_in = found_ff + 1'b1;
                     rlast_in = (found_in == cnt_ff);
                     if (rlast_in) state_in = S_IDLE;
                  end else begin
                     use_new = sat_add(pins_new[USAGE_W-1:0], LOAD_USAGE, lim);
                     we = 1'b1;
                     wd.key = key_ff; wd.pins = pins_new; wd.usage = use_new;
                     wd.dirty = 1'b0;
                     state_in = S_IDLE;
                  end
               end
            end else if (hand_nx == start_ff) begin
               rounds_in = rounds_ff + 1'b1;
               if ({1'b0, rounds_ff} + 1'b1 >= {1'b0, lim}) begin
                  rv_in = 1'b1; rslot_in = '0; rst_in = ST_ALL_PINNED;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; hand_ff <= '0; occ_ff <= '0; valid_ff <= '0; rv_ff <= 1'b0;
         max_usage_ff <= MAX_USAGE_RST; capacity_ff <= CAPACITY_RST;
         pin_limit_ff <= PIN_LIMIT_RST;
      end else begin
         state_ff <= state_in; hand_ff <= hand_in; occ_ff <= occ_in; valid_ff <= valid_in;
         rv_ff <= rv_in;
         max_usage_ff <= max_usage_in; capacity_ff <= capacity_in;
         pin_limit_ff <= pin_limit_in;
      end
      cmd_ff <= cmd_in; slot_ff <= slot_in; key_ff <= key_in; dirty_ff <= dirty_in;
      cnt_ff <= cnt_in; found_ff <= found_in; start_ff <= start_in; rounds_ff <= rounds_in;
      scan_ff <= scan_in;
      rslot_ff <= rslot_in; rvv_ff <= rvv_in; rvk_ff <= rvk_in; rvd_ff <= rvd_in;
      rst_ff <= rst_in; rlast_ff <= rlast_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rv_ff;
   assign rsp_slot_out     = rslot_ff;
   assign rsp_victim_valid = rvv_ff;
   assign rsp_victim_key   = rvk_ff;
   assign rsp_victim_dirty = rvd_ff;
   assign rsp_status       = rst_ff;
   assign rsp_last         = rlast_ff;

`ifndef SYNTHESIS
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy) else $error("busy after final item result");
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= SLOTS) else $error("occupied count out of range");
   a_victim_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_victim_valid |-> rsp_status == ST_OK)
      else $error("victim reported with error status");
   a_occ_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> 32'(occ_ff) == $countones(valid_ff))
      else $error("occupied count disagrees with valid bits");
`endif

endmodule
